@@ rtl/dtok_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and character codes for the delimiter tokenizer.
// No dependencies.
package dtok_pkg;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_NO_DATA = 8'hFF;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  // flush = 0: append ch to the store
  // flush = 1: flush store, then emit ch as its own token if emit is set
  typedef struct packed {
    logic       flush;
    logic       emit;
    logic [7:0] ch;
  } cmd_t;

endpackage

@@ rtl/dtok_front.sv @@
`timescale 1ns / 1ps
// Front end: configuration register and byte classification into commands.
// Depends on dtok_pkg.
module dtok_front import dtok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_cmd
);

  logic       return_comma;
  logic [7:0] c;
  logic       is_delim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      return_comma <= 1'b0;
    end else if (cfg_valid) begin
      return_comma <= cfg_data;
    end
  end

  always_comb begin
    c = (in_char == CH_CR) ? CH_LF : in_char;
    is_delim = (c == CH_LF) || (c == CH_SEMI) || (c == CH_COLON) ||
               (c == CH_COMMA) || (c == CH_RBRACK) || (c == CH_LBRACK);
    push_cmd.flush = is_delim || (c == CH_NUL);
    push_cmd.emit  = is_delim && ((c != CH_COMMA) || return_comma);
    push_cmd.ch    = c;
    push_valid     = in_valid && (in_char != CH_NO_DATA);
    in_ready       = push_ready;
  end

endmodule

@@ rtl/dtok_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on dtok_pkg.
module dtok_queue import dtok_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);

  cmd_t               entries [QDEPTH];
  logic [QPW-1:0]     wr_ptr;
  logic [QPW-1:0]     rd_ptr;
  logic [QPW:0]       count;
  logic               push;
  logic               pop;

  always_comb begin
    push_ready = (count != (QPW+1)'(QDEPTH));
    q_valid    = (count != '0);
    q_cmd      = entries[rd_ptr];
    push       = push_valid && push_ready;
    pop        = q_valid && q_ready;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QDEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      if (push && !pop) begin
        count <= count + (QPW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/dtok_back.sv @@
`timescale 1ns / 1ps
// Back end: token store, append and flush sequencer, output register.
// Depends on dtok_pkg.
module dtok_back import dtok_pkg::*; #(
  parameter int TOKEN_MAX = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  cmd_t       q_cmd,
  output logic       token_valid,
  input  logic       token_ready,
  output logic [7:0] token_char,
  output logic       token_last
);

  localparam int              LW      = $clog2(TOKEN_MAX);
  localparam logic [LW-1:0]   LEN_MAX = LW'(TOKEN_MAX - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_DELIM = 2'd2;

  logic [7:0]    mem [TOKEN_MAX];
  logic [1:0]    state;
  logic [LW-1:0] length;
  logic [LW-1:0] rd_idx;
  logic [7:0]    rd_data;
  logic          pend_valid;
  logic          pend_last;
  logic          dl_emit;
  logic [7:0]    dl_char;

  logic out_free;
  logic pend_move;
  logic rd_en;
  logic pop;
  logic wr_en;
  logic delim_load;

  always_comb begin
    out_free   = !token_valid || token_ready;
    pend_move  = pend_valid && out_free;
    rd_en      = (state == ST_FLUSH) && (rd_idx < length) && (!pend_valid || pend_move);
    pop        = (state == ST_IDLE) && q_valid;
    wr_en      = pop && !q_cmd.flush && (length < LEN_MAX);
    delim_load = (state == ST_DELIM) && out_free;
    q_ready    = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[length] <= q_cmd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data   <= mem[rd_idx];
      pend_last <= (rd_idx == length - LW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.flush) begin
      dl_emit <= q_cmd.emit;
      dl_char <= q_cmd.ch;
    end
    if (pend_move) begin
      token_char <= rd_data;
      token_last <= pend_last;
    end else if (delim_load) begin
      token_char <= dl_char;
      token_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      length      <= '0;
      rd_idx      <= '0;
      pend_valid  <= 1'b0;
      token_valid <= 1'b0;
    end else begin
      if (pend_move || delim_load) begin
        token_valid <= 1'b1;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (q_cmd.flush) begin
              rd_idx <= '0;
              if (length != '0) begin
                state <= ST_FLUSH;
              end else if (q_cmd.emit) begin
                state <= ST_DELIM;
              end
            end else if (wr_en) begin
              length <= length + LW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (rd_en) begin
            rd_idx     <= rd_idx + LW'(1);
            pend_valid <= 1'b1;
          end else if (pend_move) begin
            pend_valid <= 1'b0;
          end
          if (pend_move && pend_last) begin
            length <= '0;
            state  <= dl_emit ? ST_DELIM : ST_IDLE;
          end
        end
        ST_DELIM: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_MAX)
    else $error("token length above store limit");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (length != '0))
    else $error("flush running on empty store");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (rd_idx < length))
    else $error("store read beyond token length");

  a_pend_in_flush: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == ST_FLUSH))
    else $error("read data pending outside flush");

  a_flush_ends_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FLUSH) && pend_move && pend_last) |=> (length == '0))
    else $error("store not cleared after flush");

endmodule

@@ rtl/delimiter_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// Top level of the delimiter tokenizer.
// Depends on dtok_pkg, dtok_front, dtok_queue, dtok_back.
//
// Usage:
//   in_valid/in_ready/in_char carry received bytes. 0xFF is taken and
//   dropped; CR is handled as LF. Ordinary bytes are appended to a token
//   store of TOKEN_MAX-1 characters, extra bytes are discarded.
//   A delimiter (LF ; : , ] [) or NUL flushes the stored token on
//   token_valid/token_ready, one token_char per transaction, token_last
//   on the final one. A delimiter then goes out as its own one-character
//   token; a comma only when return_comma is set.
//   cfg_valid/cfg_ready/cfg_data writes return_comma; cfg_ready is always
//   high. Write it only while the block is idle.
// Timing:
//   Bytes enter a 2-entry command queue; the back end takes one command
//   per cycle when idle, and takes none during a flush or a delimiter
//   token. A flush moves each stored character through the registered
//   store read port into the output register, one per cycle while
//   token_ready is high, then sends any delimiter token. Reset clears
//   the store length, the queue and return_comma. A stall on
//   token_ready holds the output register, the flush stops, and the queue
//   fills and lowers in_ready.
module delimiter_tokenizer_unit import dtok_pkg::*; #(
  parameter int TOKEN_MAX = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       token_valid,
  input  logic       token_ready,
  output logic [7:0] token_char,
  output logic       token_last
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  dtok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  dtok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd)
  );

  dtok_back #(
    .TOKEN_MAX (TOKEN_MAX)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cmd       (q_cmd),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_char  (token_char),
    .token_last  (token_last)
  );

endmodule
